### rtl/dltq_pkg.sv
// Package for the delta-list timer queue.
// Holds the request and result payload types and the opcode and status codes.
// No dependencies.
package dltq_pkg;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SCHEDULE = 2'd1;
  localparam logic [1:0] OP_CANCEL   = 2'd2;

  localparam logic [2:0] ST_FIRED          = 3'd0;
  localparam logic [2:0] ST_SCHEDULED      = 3'd1;
  localparam logic [2:0] ST_CANCELLED      = 3'd2;
  localparam logic [2:0] ST_ALREADY_QUEUED = 3'd3;
  localparam logic [2:0] ST_NOT_QUEUED     = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  timer_id;
    logic [31:0] delay_ticks;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] result_id;
    logic       last;
  } result_t;

endpackage

### rtl/delta_list_timer_queue_top.sv
// Delta-list timer queue, top level. Uses dltq_pkg and dltq_slot_ram.
// A reject, an ignored opcode or an empty-list tick never leaves idle; a tick otherwise
// reads the head and fires each due timer in turn, a schedule walks the list to its
// insertion point and a cancel walks to the timer, then both relink it.
// Results are registered, one per cycle; throughput is one request at a time.
// Synchronous active-high reset empties the queue; the result receiver cannot stall.
module delta_list_timer_queue_top
  import dltq_pkg::*;
#(
  parameter int MAX_TIMERS = 16,
  parameter int DELAY_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     result_valid,
  output result_t  result
);

  // Slot address width, and link width that also holds the end-of-list mark.
  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int IW = $clog2(MAX_TIMERS + 1);
  localparam int DW = DELAY_BITS;
  localparam logic [IW-1:0] NO_SLOT = IW'(MAX_TIMERS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_FIRE,
    S_FLUSH,
    S_SWALK,
    S_SSUCC,
    S_SLINK,
    S_CWALK,
    S_CSUCC,
    S_CLINK
  } state_t;

  state_t state;

  // Request registers.
  logic [3:0]      id_r;
  logic [DW-1:0]   d_r;

  // Queue state outside the RAM.
  logic [IW-1:0]   head;
  logic [MAX_TIMERS-1:0] queued;

  // Walk registers.
  logic [DW-1:0]   acc;
  logic [DW-1:0]   sum_reg;
  logic [DW-1:0]   cur_delta;
  logic [IW-1:0]   prev;
  logic [IW-1:0]   cur;
  logic [IW-1:0]   fire_id;

  // RAM ports.
  logic [AW-1:0]   rd_addr;
  logic [DW-1:0]   q_delta;
  logic [IW-1:0]   q_next;
  logic            delta_we;
  logic [AW-1:0]   delta_addr;
  logic [DW-1:0]   delta_wdata;
  logic            next_we;
  logic [AW-1:0]   next_addr;
  logic [IW-1:0]   next_wdata;

  logic            accept;
  logic            req_id_ok;
  logic            req_queued;
  logic [DW-1:0]   tick_dec;
  logic [DW:0]     walk_sum;
  logic            walk_stop;

  dltq_slot_ram #(
    .DEPTH(MAX_TIMERS),
    .AW   (AW),
    .DW   (DW),
    .NW   (IW)
  ) u_ram (
    .clk        (clk),
    .rd_addr    (rd_addr),
    .rd_delta   (q_delta),
    .rd_next    (q_next),
    .delta_we   (delta_we),
    .delta_addr (delta_addr),
    .delta_wdata(delta_wdata),
    .next_we    (next_we),
    .next_addr  (next_addr),
    .next_wdata (next_wdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Slot numbers at or above the queue size are rejected as not queued.
  assign req_id_ok  = (9'(request.timer_id) < 9'(MAX_TIMERS));
  assign req_queued = queued[AW'(request.timer_id)];

  // The head's delta counts down and saturates at zero.
  assign tick_dec = (q_delta == '0) ? '0 : q_delta - DW'(1);

  // Expiry of the entry just read; the new timer goes in front of the first
  // entry that expires strictly later, so equal expiries keep arrival order.
  assign walk_sum  = {1'b0, acc} + {1'b0, q_delta};
  assign walk_stop = ({1'b0, d_r} < walk_sum);

  // RAM control. Reads are issued in the state before the one that uses the
  // data; the read address follows the link just returned by the RAM. A state
  // that both reads and writes never touches the same entry with both, and every
  // write lands before the next request's first read, so no forwarding is needed.
  always_comb begin
    rd_addr     = AW'(head);
    delta_we    = 1'b0;
    delta_addr  = AW'(cur);
    delta_wdata = '0;
    next_we     = 1'b0;
    next_addr   = AW'(prev);
    next_wdata  = cur;
    unique case (state)
      S_IDLE: begin
        rd_addr = AW'(head);
      end
      S_TICK: begin
        rd_addr = AW'(q_next);
        if (tick_dec != '0) begin
          delta_we    = 1'b1;
          delta_addr  = AW'(head);
          delta_wdata = tick_dec;
        end
      end
      S_FIRE, S_SWALK, S_CWALK: begin
        rd_addr = AW'(q_next);
      end
      S_SSUCC: begin
        // Successor gives up the part of its delta now held by the new timer.
        if (cur != NO_SLOT) begin
          delta_we    = 1'b1;
          delta_addr  = AW'(cur);
          delta_wdata = sum_reg - d_r;
        end
        if (prev != NO_SLOT) begin
          next_we    = 1'b1;
          next_addr  = AW'(prev);
          next_wdata = IW'(id_r);
        end
      end
      S_SLINK: begin
        delta_we    = 1'b1;
        delta_addr  = AW'(id_r);
        delta_wdata = d_r - acc;
        next_we     = 1'b1;
        next_addr   = AW'(id_r);
        next_wdata  = cur;
      end
      S_CSUCC: begin
        // The successor absorbs the cancelled timer's delta.
        delta_we    = 1'b1;
        delta_addr  = AW'(cur);
        delta_wdata = q_delta + cur_delta;
        if (prev != NO_SLOT) begin
          next_we = 1'b1;
        end
      end
      S_CLINK: begin
        if (prev != NO_SLOT) begin
          next_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= NO_SLOT;
      queued       <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            id_r <= request.timer_id;
            d_r  <= DW'(request.delay_ticks);
            acc  <= '0;
            prev <= NO_SLOT;
            cur  <= head;
            unique case (request.opcode)
              OP_TICK: begin
                if (head != NO_SLOT) begin
                  state <= S_TICK;
                end
              end
              OP_SCHEDULE: begin
                if (!req_id_ok) begin
                  result_valid <= 1'b1;
                  result       <= '{ST_NOT_QUEUED, request.timer_id, 1'b1};
                end else if (req_queued) begin
                  result_valid <= 1'b1;
                  result       <= '{ST_ALREADY_QUEUED, request.timer_id, 1'b1};
                end else if (head == NO_SLOT) begin
                  state <= S_SSUCC;
                end else begin
                  state <= S_SWALK;
                end
              end
              OP_CANCEL: begin
                if (!req_id_ok || !req_queued) begin
                  result_valid <= 1'b1;
                  result       <= '{ST_NOT_QUEUED, request.timer_id, 1'b1};
                end else begin
                  state <= S_CWALK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_TICK: begin
          if (tick_dec == '0) begin
            queued[AW'(head)] <= 1'b0;
            fire_id           <= head;
            head              <= q_next;
            if (q_next == NO_SLOT) begin
              result_valid <= 1'b1;
              result       <= '{ST_FIRED, 4'(head), 1'b1};
              state        <= S_IDLE;
            end else begin
              state <= S_FIRE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_FIRE: begin
          // The pending fired timer is last unless the new head is due too.
          result_valid <= 1'b1;
          if (q_delta == '0) begin
            result            <= '{ST_FIRED, 4'(fire_id), 1'b0};
            queued[AW'(head)] <= 1'b0;
            fire_id           <= head;
            head              <= q_next;
            if (q_next == NO_SLOT) begin
              state <= S_FLUSH;
            end
          end else begin
            result <= '{ST_FIRED, 4'(fire_id), 1'b1};
            state  <= S_IDLE;
          end
        end
        S_FLUSH: begin
          result_valid <= 1'b1;
          result       <= '{ST_FIRED, 4'(fire_id), 1'b1};
          state        <= S_IDLE;
        end
        S_SWALK: begin
          if (walk_stop) begin
            sum_reg <= walk_sum[DW-1:0];
            state   <= S_SSUCC;
          end else begin
            acc  <= walk_sum[DW-1:0];
            prev <= cur;
            cur  <= q_next;
            if (q_next == NO_SLOT) begin
              state <= S_SSUCC;
            end
          end
        end
        S_SSUCC: begin
          if (prev == NO_SLOT) begin
            head <= IW'(id_r);
          end
          state <= S_SLINK;
        end
        S_SLINK: begin
          queued[AW'(id_r)] <= 1'b1;
          result_valid      <= 1'b1;
          result            <= '{ST_SCHEDULED, id_r, 1'b1};
          state             <= S_IDLE;
        end
        S_CWALK: begin
          if (cur == IW'(id_r)) begin
            cur_delta <= q_delta;
            cur       <= q_next;
            state     <= (q_next == NO_SLOT) ? S_CLINK : S_CSUCC;
          end else if (q_next == NO_SLOT) begin
            // Slot marked queued but not on the list: only the mark is dropped.
            queued[AW'(id_r)] <= 1'b0;
            result_valid      <= 1'b1;
            result            <= '{ST_CANCELLED, id_r, 1'b1};
            state             <= S_IDLE;
          end else begin
            prev <= cur;
            cur  <= q_next;
          end
        end
        S_CSUCC, S_CLINK: begin
          if (prev == NO_SLOT) begin
            head <= cur;
          end
          queued[AW'(id_r)] <= 1'b0;
          result_valid      <= 1'b1;
          result            <= '{ST_CANCELLED, id_r, 1'b1};
          state             <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A fired timer that is not the last one is always followed at once by another.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |=> result_valid)
    else $error("non-final result not followed by another result");

  // Only the expiry run of a tick produces results that are not final.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_FIRED)) |-> result.last)
    else $error("single-result request without last flag");

  // An empty list means no slot may still be marked as queued.
  assert property (@(posedge clk) disable iff (rst)
    (head == NO_SLOT) |-> (queued == '0))
    else $error("queued slot with empty list");

  // Results only follow from work in progress.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy) || $past(start))
    else $error("result without a request");

endmodule

### rtl/dltq_slot_ram.sv
// Slot storage of the timer queue: per-slot delta and successor link.
// Two single-write-port memories sharing one read address, with registered read data.
// No package dependencies.
module dltq_slot_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32,
  parameter int NW    = 5
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_delta,
  output logic [NW-1:0] rd_next,
  input  logic          delta_we,
  input  logic [AW-1:0] delta_addr,
  input  logic [DW-1:0] delta_wdata,
  input  logic          next_we,
  input  logic [AW-1:0] next_addr,
  input  logic [NW-1:0] next_wdata
);

  logic [DW-1:0] delta_mem [DEPTH];
  logic [NW-1:0] next_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (delta_we) begin
      delta_mem[delta_addr] <= delta_wdata;
    end
    rd_delta <= delta_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_addr] <= next_wdata;
    end
    rd_next <= next_mem[rd_addr];
  end

endmodule
